// ===== design/spa_pkg.sv =====
// Shared types and constants for the sweep point averager.
package spa_pkg;

    localparam int LANES      = 4;
    localparam int ACC_BITS   = 48;
    localparam int MEAN_BITS  = 32;
    localparam int CNT_BITS   = 16;
    localparam int DIV_STEPS  = MEAN_BITS;
    localparam int STEP_BITS  = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    localparam logic REG_AVERAGE_COUNT = 1'b0;
    localparam logic REG_POINT_COUNT   = 1'b1;

    localparam logic [CNT_BITS-1:0] RATE_MIN      = 16'd5;
    localparam logic [CNT_BITS-1:0] RATE_MAX      = 16'd50000;
    localparam logic [CNT_BITS-1:0] SIZE_MIN      = 16'd1;
    localparam logic [CNT_BITS-1:0] SIZE_MAX      = 16'd32768;
    localparam logic [CNT_BITS-1:0] RATE_RESET    = 16'd5;
    localparam logic [CNT_BITS-1:0] SIZE_RESET    = 16'd6000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] sample_a;
        logic signed [31:0] sample_b;
        logic signed [31:0] sample_c;
        logic signed [31:0] sample_d;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] mean_a;
        logic signed [31:0] mean_b;
        logic signed [31:0] mean_c;
        logic signed [31:0] mean_d;
        logic               final_point;
    } out_item_t;

    typedef struct packed {
        logic clr;
        logic add;
        logic go;
        logic take;
    } lane_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lane_stat_t;

endpackage

// ===== design/spa_lane.sv =====
// One averaging lane: 48-bit accumulator and a bit-serial divider by the rate.
module spa_lane
    import spa_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lane_ctl_t             ctl,
    input  logic [31:0]           sample,
    input  logic [CNT_BITS-1:0]   rate,
    output lane_stat_t            stat,
    output logic [MEAN_BITS-1:0]  mean
);

    logic signed [ACC_BITS-1:0]  acc_reg;
    logic                        go_reg;
    logic [STEP_BITS-1:0]        step_reg;
    logic                        done_reg;
    logic                        neg_reg;
    logic [CNT_BITS-1:0]         rem_reg;
    logic [MEAN_BITS-1:0]        dq_reg;

    logic signed [SAMPLE_BITS-1:0] sample_low;
    logic signed [ACC_BITS-1:0]    sample_ext;
    logic [ACC_BITS-1:0]           mag;
    logic [CNT_BITS:0]             shifted;
    logic [CNT_BITS:0]             diff;
    logic                          ge;

    assign sample_low = $signed(sample[SAMPLE_BITS-1:0]);
    assign sample_ext = ACC_BITS'(sample_low);
    assign mag        = acc_reg[ACC_BITS-1] ? (-acc_reg) : acc_reg;
    assign shifted    = {rem_reg, dq_reg[MEAN_BITS-1]};
    assign diff       = shifted - {1'b0, rate};
    assign ge         = (shifted >= {1'b0, rate});

    always_ff @(posedge clk)
    begin
        if (ctl.clr)
        begin
            acc_reg <= '0;
        end
        else if (ctl.add)
        begin
            acc_reg <= acc_reg + sample_ext;
        end
    end

    // Remainder starts from the top bits; it is already below the rate
    // because the magnitude never exceeds rate times 2^31.
    always_ff @(posedge clk)
    begin
        if (go_reg)
        begin
            neg_reg <= acc_reg[ACC_BITS-1];
            rem_reg <= mag[ACC_BITS-1:MEAN_BITS];
            dq_reg  <= mag[MEAN_BITS-1:0];
        end
        else if (step_reg != '0)
        begin
            rem_reg <= ge ? diff[CNT_BITS-1:0] : shifted[CNT_BITS-1:0];
            dq_reg  <= {dq_reg[MEAN_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg   <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            go_reg <= ctl.go;
            if (go_reg)
            begin
                step_reg <= STEP_BITS'(DIV_STEPS);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - 1'b1;
            end
            if (step_reg == STEP_BITS'(1))
            begin
                done_reg <= 1'b1;
            end
            else if (ctl.take)
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign stat.busy = go_reg || (step_reg != '0);
    assign stat.done = done_reg;
    assign mean      = neg_reg ? (-dq_reg) : dq_reg;

endmodule

// ===== design/spa_merge.sv =====
// Merging stage: gathers the four lane quotients into the output register.
module spa_merge
    import spa_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             lanes_done,
    input  logic [LANES-1:0][MEAN_BITS-1:0]  means,
    input  logic                             final_point,
    output logic                             take,
    output logic                             out_valid,
    input  logic                             out_ready,
    output out_item_t                        out_item
);

    logic      valid_reg;
    out_item_t item_reg;

    assign take = lanes_done && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.mean_a      <= means[0];
            item_reg.mean_b      <= means[1];
            item_reg.mean_c      <= means[2];
            item_reg.mean_d      <= means[3];
            item_reg.final_point <= final_point;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== design/sweep_point_averager_top.sv =====
// Sweep point averager: settling discard, four-lane boxcar sum, serial divide.
// Throughput: one item per cycle, except that after the last set of a point
// input stalls while the lane dividers run 32 steps (one per cycle) and until
// the merge stage takes the quotients into its output register.
// Reset: rst_n clears sweep, counters and handshake flags; the configuration
// registers return to 5 and 6000; the lane sums need no reset (start clears).
module sweep_point_averager_top
    import spa_pkg::*;
#(
    parameter int SETTLE_SETS = 5,
    parameter int SAMPLE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CNT_BITS-1:0]   cfg_data
);

    localparam logic [CNT_BITS-1:0] SETTLE = CNT_BITS'(SETTLE_SETS);

    logic [CNT_BITS-1:0] avg_count_reg;
    logic [CNT_BITS-1:0] pt_count_reg;
    logic [CNT_BITS-1:0] held_rate_reg;
    logic [CNT_BITS-1:0] held_size_reg;
    logic                active_reg;
    logic [CNT_BITS-1:0] phase_reg;
    logic [CNT_BITS-1:0] points_reg;
    logic                final_reg;

    logic                accept;
    logic [CNT_BITS-1:0] phase_inc;
    logic [CNT_BITS-1:0] points_inc;
    logic                is_sample;
    logic                point_end;
    lane_ctl_t           ctl;
    lane_stat_t          stat [LANES];
    logic [LANES-1:0][MEAN_BITS-1:0] means;
    logic [LANES-1:0][31:0]          samples;
    logic                take;

    assign accept     = in_valid && in_ready;
    assign in_ready   = !stat[0].busy && !stat[0].done;
    assign phase_inc  = phase_reg + 1'b1;
    assign points_inc = points_reg + 1'b1;
    assign is_sample  = accept && (in_item.opcode == OP_SAMPLE) && active_reg;
    assign point_end  = is_sample && (phase_inc >= SETTLE + held_rate_reg);

    assign ctl.clr  = (accept && (in_item.opcode == OP_START))
                      || (is_sample && (phase_reg < SETTLE));
    assign ctl.add  = is_sample && (phase_reg >= SETTLE);
    assign ctl.go   = point_end;
    assign ctl.take = take;

    assign samples[0] = in_item.sample_a;
    assign samples[1] = in_item.sample_b;
    assign samples[2] = in_item.sample_c;
    assign samples[3] = in_item.sample_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_count_reg <= RATE_RESET;
            pt_count_reg  <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AVERAGE_COUNT: avg_count_reg <= cfg_data;
                REG_POINT_COUNT:   pt_count_reg  <= cfg_data;
                default:           avg_count_reg <= avg_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_rate_reg <= RATE_RESET;
            held_size_reg <= SIZE_RESET;
            active_reg    <= 1'b0;
            phase_reg     <= '0;
            points_reg    <= '0;
            final_reg     <= 1'b0;
        end
        else if (accept)
        begin
            case (in_item.opcode)
                OP_START:
                begin
                    // Clamp the configuration into range as the sweep opens.
                    if (avg_count_reg < RATE_MIN)
                        held_rate_reg <= RATE_MIN;
                    else if (avg_count_reg > RATE_MAX)
                        held_rate_reg <= RATE_MAX;
                    else
                        held_rate_reg <= avg_count_reg;
                    if (pt_count_reg < SIZE_MIN)
                        held_size_reg <= SIZE_MIN;
                    else if (pt_count_reg > SIZE_MAX)
                        held_size_reg <= SIZE_MAX;
                    else
                        held_size_reg <= pt_count_reg;
                    active_reg <= 1'b1;
                    phase_reg  <= '0;
                    points_reg <= '0;
                end
                OP_CANCEL:
                begin
                    active_reg <= 1'b0;
                end
                OP_SAMPLE:
                begin
                    if (point_end)
                    begin
                        phase_reg  <= '0;
                        points_reg <= points_inc;
                        final_reg  <= (points_inc >= held_size_reg);
                        if (points_inc >= held_size_reg)
                            active_reg <= 1'b0;
                    end
                    else if (active_reg)
                    begin
                        phase_reg <= phase_inc;
                    end
                end
                default:
                begin
                    active_reg <= active_reg;
                end
            endcase
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        spa_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .sample (samples[g]),
            .rate   (held_rate_reg),
            .stat   (stat[g]),
            .mean   (means[g])
        );
    end

    spa_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .lanes_done  (stat[0].done && stat[1].done && stat[2].done && stat[3].done),
        .means       (means),
        .final_point (final_reg),
        .take        (take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

endmodule

// ===== design/spa_checker.sv =====
// Port-level checks for the sweep point averager, bound to the top level.
module spa_checker
    import spa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result changed or dropped");

    // A new result only follows a divide, during which input is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a preceding divide");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready, 8))
        else $error("result appeared too soon after its last item");

    // Input stays blocked through the last steps of the divide.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready, 2))
        else $error("input accepted during divide");

endmodule

bind sweep_point_averager_top spa_checker u_spa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
